/* sv/midpoint_ellipse_rasterizer_defines.svh */
// Assertion helpers shared by the ellipse rasterizer.
// Both expect clk and arst_n in scope; checks are off while reset is low.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define MER_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MER_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mer_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

	localparam int COORD_W  = 10;
	localparam int STEP_W   = COORD_W + 2;   // running x/y, signed
	localparam int PIX_W    = COORD_W + 2;   // output coordinate, signed
	localparam int PSUM_W   = COORD_W + 3;   // center +/- offset before trim
	localparam int SQ_W     = 2 * COORD_W;   // a*a, b*b
	localparam int SUM_W    = SQ_W + 1;      // a*a + b*b
	localparam int QUAD_W   = 4 * COORD_W;   // a^4, b^4
	localparam int MUL_W    = SQ_W + 4;      // multiplier operand, signed
	localparam int PROD_W   = 2 * MUL_W;     // product and decision width
	localparam int QUAD_SEL = 2;
	localparam int IN_TDATA_W  = 4 * COORD_W;
	localparam int OUT_TDATA_W = ((2 * PIX_W + QUAD_SEL + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	localparam logic signed [MUL_W-1:0] INC_K = MUL_W'(3);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [1:0] {
		PH_DONE,
		PH_ONE,
		PH_TWO
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_A2,
		ST_LD_B2,
		ST_LD_A4,
		ST_LD_B4,
		ST_LD_DEC,
		ST_LD_END,
		ST_SQ,
		ST_MUL_S,
		ST_CMP,
		ST_TR_END,
		ST_EMIT,
		ST_INC,
		ST_TERM,
		ST_UPD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [PIX_W-1:0]    pixel_x;
		logic [PIX_W-1:0]    pixel_y;
		logic [QUAD_SEL-1:0] quadrant;
		logic                pixel_valid;
		logic                last;
		logic                finished;
	} res_t;

endpackage

`default_nettype wire

/* sv/mer_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// shared signed multiplier, product registered
module mer_mul (
	input  wire logic                               clk,
	input  wire logic signed [mer_pkg::MUL_W-1:0]   op_a,
	input  wire logic signed [mer_pkg::MUL_W-1:0]   op_b,
	output logic signed      [mer_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

`default_nettype wire

/* sv/mer_oreg.sv */
`timescale 1ns / 1ps
`default_nettype none

// one-entry output register between the sequencer and the master port
module mer_oreg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire mer_pkg::res_t in_res,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mer_pkg::res_t      out_res
);

	logic          valid_q;
	mer_pkg::res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

`default_nettype wire

/* sv/mer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// sequencer and datapath around the shared multiplier
module mer_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  in_op,
	input  wire logic        [mer_pkg::COORD_W-1:0]    in_cx,
	input  wire logic        [mer_pkg::COORD_W-1:0]    in_cy,
	input  wire logic        [mer_pkg::COORD_W-1:0]    in_ra,
	input  wire logic        [mer_pkg::COORD_W-1:0]    in_rb,
	output logic signed      [mer_pkg::MUL_W-1:0]      mul_a,
	output logic signed      [mer_pkg::MUL_W-1:0]      mul_b,
	input  wire logic signed [mer_pkg::PROD_W-1:0]     mul_p,
	output logic                                       res_valid,
	input  wire logic                                  res_ready,
	output mer_pkg::res_t                              res
);

	mer_pkg::state_t state_q, state_d;
	mer_pkg::phase_t phase_q;
	logic [1:0]      k_q;

	logic        [mer_pkg::COORD_W-1:0] cx_q, cy_q, ra_q, rb_q;
	logic        [mer_pkg::SQ_W-1:0]    a2_q, b2_q;
	logic        [mer_pkg::SUM_W-1:0]   s_q;
	logic        [mer_pkg::QUAD_W-1:0]  a4_q, b4_q;
	logic signed [mer_pkg::STEP_W-1:0]  x_q, y_q;
	logic signed [mer_pkg::PROD_W-1:0]  dec_q, inc_q;

	// region one runs x (t) against y (u); region two swaps them
	logic                               reg_one;
	logic signed [mer_pkg::STEP_W-1:0]  t_cur, u_cur;
	logic        [mer_pkg::QUAD_W-1:0]  lim4;
	logic        [mer_pkg::SQ_W-1:0]    sq_inc, sq_cross;
	logic                               pass;
	logic signed [mer_pkg::PSUM_W-1:0]  px_p, px_m, py_p, py_m;

	assign reg_one  = (phase_q == mer_pkg::PH_ONE);
	assign t_cur    = reg_one ? x_q : y_q;
	assign u_cur    = reg_one ? y_q : x_q;
	assign lim4     = reg_one ? a4_q : b4_q;
	assign sq_inc   = reg_one ? b2_q : a2_q;
	assign sq_cross = reg_one ? a2_q : b2_q;
	assign pass     = (mul_p <= $signed(mer_pkg::PROD_W'(lim4)));

	assign px_p = $signed(mer_pkg::PSUM_W'(cx_q)) + mer_pkg::PSUM_W'(x_q);
	assign px_m = $signed(mer_pkg::PSUM_W'(cx_q)) - mer_pkg::PSUM_W'(x_q);
	assign py_p = $signed(mer_pkg::PSUM_W'(cy_q)) + mer_pkg::PSUM_W'(y_q);
	assign py_m = $signed(mer_pkg::PSUM_W'(cy_q)) - mer_pkg::PSUM_W'(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == mer_pkg::OP_START) begin
						state_d = mer_pkg::ST_LD_A2;
					end else if (phase_q == mer_pkg::PH_DONE) begin
						state_d = mer_pkg::ST_FIN;
					end else begin
						state_d = mer_pkg::ST_SQ;
					end
				end
			end
			mer_pkg::ST_LD_A2: begin
				mul_a   = mer_pkg::MUL_W'(ra_q);
				mul_b   = mer_pkg::MUL_W'(ra_q);
				state_d = mer_pkg::ST_LD_B2;
			end
			mer_pkg::ST_LD_B2: begin
				mul_a   = mer_pkg::MUL_W'(rb_q);
				mul_b   = mer_pkg::MUL_W'(rb_q);
				state_d = mer_pkg::ST_LD_A4;
			end
			mer_pkg::ST_LD_A4: begin
				mul_a   = mer_pkg::MUL_W'(a2_q);
				mul_b   = mer_pkg::MUL_W'(a2_q);
				state_d = mer_pkg::ST_LD_B4;
			end
			mer_pkg::ST_LD_B4: begin
				mul_a   = mer_pkg::MUL_W'(b2_q);
				mul_b   = mer_pkg::MUL_W'(b2_q);
				state_d = mer_pkg::ST_LD_DEC;
			end
			mer_pkg::ST_LD_DEC: begin
				mul_a   = mer_pkg::MUL_W'(a2_q);
				mul_b   = mer_pkg::MUL_W'(rb_q);
				state_d = mer_pkg::ST_LD_END;
			end
			mer_pkg::ST_LD_END: begin
				state_d = mer_pkg::ST_IDLE;
			end
			mer_pkg::ST_SQ: begin
				mul_a   = mer_pkg::MUL_W'(t_cur);
				mul_b   = mer_pkg::MUL_W'(t_cur);
				state_d = mer_pkg::ST_MUL_S;
			end
			mer_pkg::ST_MUL_S: begin
				mul_a   = mul_p[mer_pkg::MUL_W-1:0];
				mul_b   = mer_pkg::MUL_W'(s_q);
				state_d = mer_pkg::ST_CMP;
			end
			mer_pkg::ST_CMP: begin
				if (pass) begin
					state_d = mer_pkg::ST_EMIT;
				end else if (reg_one) begin
					// switch to region two: decision starts at a2 - a*b2
					mul_a   = mer_pkg::MUL_W'(ra_q);
					mul_b   = mer_pkg::MUL_W'(b2_q);
					state_d = mer_pkg::ST_TR_END;
				end else begin
					state_d = mer_pkg::ST_FIN;
				end
			end
			mer_pkg::ST_TR_END: begin
				state_d = mer_pkg::ST_SQ;
			end
			mer_pkg::ST_EMIT: begin
				res_valid        = 1'b1;
				res.quadrant     = k_q;
				res.pixel_valid  = 1'b1;
				res.last         = (k_q == 2'd3);
				res.pixel_x      = k_q[1] ? px_m[mer_pkg::PIX_W-1:0]
				                          : px_p[mer_pkg::PIX_W-1:0];
				res.pixel_y      = (k_q == 2'd1 || k_q == 2'd2) ? py_m[mer_pkg::PIX_W-1:0]
				                                                : py_p[mer_pkg::PIX_W-1:0];
				if (res_ready && k_q == 2'd3) begin
					state_d = mer_pkg::ST_INC;
				end
			end
			mer_pkg::ST_INC: begin
				mul_a   = (mer_pkg::MUL_W'(t_cur) <<< 1) + mer_pkg::INC_K;
				mul_b   = mer_pkg::MUL_W'(sq_inc);
				state_d = mer_pkg::ST_TERM;
			end
			mer_pkg::ST_TERM: begin
				// u - 1 may be negative in the degenerate shapes
				mul_a   = mer_pkg::MUL_W'(sq_cross);
				mul_b   = mer_pkg::MUL_W'(u_cur - $signed(mer_pkg::STEP_W'(1)));
				state_d = mer_pkg::ST_UPD;
			end
			mer_pkg::ST_UPD: begin
				state_d = mer_pkg::ST_IDLE;
			end
			mer_pkg::ST_FIN: begin
				res_valid    = 1'b1;
				res.last     = 1'b1;
				res.finished = 1'b1;
				if (res_ready) begin
					state_d = mer_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mer_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mer_pkg::PH_DONE;
			k_q     <= 2'd0;
		end else begin
			case (state_q)
				mer_pkg::ST_LD_END: begin
					phase_q <= (ra_q == '0 && rb_q == '0) ? mer_pkg::PH_DONE
					                                       : mer_pkg::PH_ONE;
				end
				mer_pkg::ST_CMP: begin
					k_q <= 2'd0;
					if (!pass) begin
						phase_q <= reg_one ? mer_pkg::PH_TWO : mer_pkg::PH_DONE;
					end
				end
				mer_pkg::ST_EMIT: begin
					if (res_ready) begin
						k_q <= k_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mer_pkg::ST_IDLE: begin
				if (in_valid && in_op == mer_pkg::OP_START) begin
					cx_q <= in_cx;
					cy_q <= in_cy;
					ra_q <= in_ra;
					rb_q <= in_rb;
					x_q  <= '0;
					y_q  <= mer_pkg::STEP_W'(in_rb);
				end
			end
			mer_pkg::ST_LD_B2: begin
				a2_q <= mul_p[mer_pkg::SQ_W-1:0];
			end
			mer_pkg::ST_LD_A4: begin
				b2_q <= mul_p[mer_pkg::SQ_W-1:0];
				s_q  <= mer_pkg::SUM_W'(a2_q) + mer_pkg::SUM_W'(mul_p[mer_pkg::SQ_W-1:0]);
			end
			mer_pkg::ST_LD_B4: begin
				a4_q <= mul_p[mer_pkg::QUAD_W-1:0];
			end
			mer_pkg::ST_LD_DEC: begin
				b4_q <= mul_p[mer_pkg::QUAD_W-1:0];
			end
			mer_pkg::ST_LD_END: begin
				dec_q <= mer_pkg::PROD_W'(b2_q) - mul_p;
			end
			mer_pkg::ST_CMP: begin
				if (!pass && reg_one) begin
					x_q <= mer_pkg::STEP_W'(ra_q);
					y_q <= '0;
				end
			end
			mer_pkg::ST_TR_END: begin
				dec_q <= mer_pkg::PROD_W'(a2_q) - mul_p;
			end
			mer_pkg::ST_TERM: begin
				inc_q <= mul_p;
			end
			mer_pkg::ST_UPD: begin
				if (dec_q[mer_pkg::PROD_W-1]) begin
					dec_q <= dec_q + inc_q;
				end else begin
					dec_q <= dec_q + inc_q - (mul_p <<< 1);
				end
				if (reg_one) begin
					x_q <= x_q + mer_pkg::STEP_W'(1);
					if (!dec_q[mer_pkg::PROD_W-1]) begin
						y_q <= y_q - mer_pkg::STEP_W'(1);
					end
				end else begin
					y_q <= y_q + mer_pkg::STEP_W'(1);
					if (!dec_q[mer_pkg::PROD_W-1]) begin
						x_q <= x_q - mer_pkg::STEP_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/midpoint_ellipse_rasterizer.sv */
// Midpoint ellipse rasterizer, axis aligned, two regions.
// Input stream (s_axis_*): tuser is the opcode. A start item (tuser = 0)
// loads center and radii from tdata and returns nothing. A step item
// (tuser = 1) advances one iteration and returns four items, one per
// quadrant, tlast on the fourth; once the ellipse is done (or before any
// start) a step returns a single item with finished set and tlast high.
// Output stream (m_axis_*): pixel coordinates are two's complement.
// Timing: one multiplier is shared by a sequencer; every product is
// registered and consumed the next cycle. A start item holds s_axis_tready
// low while it computes the squares, fourth powers and initial decision. A
// step holds it low through the bound test, the four items and the decision
// update; a step that switches from region one to region two first repeats
// the bound test for region two. The first result is offered on m_axis from
// the output register once the bound test has passed.
// The block is ready only in its idle state; items come out of a one-entry
// output register, so a stalled receiver holds the sequencer in its emit
// state and back-pressures the input side. Reset (arst_n low, async)
// empties the output register and leaves the block idle with no ellipse
// loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_ellipse_rasterizer_defines.svh"

module midpoint_ellipse_rasterizer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// center_x, center_y, radius_x, radius_y
	input  wire logic [mer_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// opcode
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// pixel_x, pixel_y, quadrant, zero pad
	output logic [mer_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	// pixel_valid, finished
	output logic [mer_pkg::OUT_TUSER_W-1:0]          m_axis_tuser,
	output logic                                     m_axis_tlast
);

	localparam int CW = mer_pkg::COORD_W;

	logic signed [mer_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [mer_pkg::PROD_W-1:0] mul_p;

	// sequencer -> output register
	logic          res_valid, res_ready;
	mer_pkg::res_t res;
	mer_pkg::res_t out_res;

	mer_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_cx     (s_axis_tdata[CW-1:0]),
		.in_cy     (s_axis_tdata[2*CW-1:CW]),
		.in_ra     (s_axis_tdata[3*CW-1:2*CW]),
		.in_rb     (s_axis_tdata[4*CW-1:3*CW]),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_p     (mul_p),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	mer_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (mul_p)
	);

	mer_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = mer_pkg::OUT_TDATA_W'({out_res.quadrant, out_res.pixel_y,
	                                            out_res.pixel_x});
	assign m_axis_tuser = {out_res.finished, out_res.pixel_valid};
	assign m_axis_tlast = out_res.last;

	// sequencer never offers a result while idle
	`MER_ASSERT_IMP(a_idle_quiet, s_axis_tready, !res_valid, "result offered while idle")
	// every accepted item starts work, so the input closes next cycle
	`MER_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"input still open after accept")
	// a finished item carries no point and closes the burst
	`MER_ASSERT_IMP(a_fin_shape, m_axis_tvalid && m_axis_tuser[1],
		!m_axis_tuser[0] && m_axis_tlast, "malformed finished item")

endmodule

`default_nettype wire
